@@ rtl/udmg_pkg.sv @@
// ----------------------------------------------------------------------------
// udmg_pkg
// Types and constants for the unsigned division magic generator.
// ----------------------------------------------------------------------------
package udmg_pkg;

	localparam int unsigned WordBits = 32;

	localparam logic [31:0] BIT31     = 32'h8000_0000;
	localparam logic [31:0] LOW31     = 32'h7FFF_FFFF;
	localparam logic [6:0]  MAX_P     = 7'd64;
	localparam logic [6:0]  START_P   = 7'd31;
	localparam logic [6:0]  WORD_BITS = 7'd32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_NC,
		ST_DIV_Q1,
		ST_DIV_Q2,
		ST_LOOP,
		ST_DONE
	} udmg_state_t;

endpackage

@@ rtl/unsigned_division_magic_generator.sv @@
// ----------------------------------------------------------------------------
// unsigned_division_magic_generator
// Granlund-Montgomery magic multiplier, add flag and post-shift for a
// 32-bit unsigned divisor, built around one shared restoring divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  command   in         start, busy           divisor
//  result    out        done (one-cycle)      multiplier, add_needed,
//                                             shift_amount, status
//
//  one word runs three serial divider passes (nc, q1/r1, q2/r2), then
//  the doubling loop, then done; the divider yields one quotient bit per
//  cycle. a zero divisor goes from idle straight to done.
//  start is taken only while busy is low, one word at a time.
//  reset clears the sequencer; the result is held on its ports after done.
//  the receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module unsigned_division_magic_generator
	import udmg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] multiplier,
	output logic        add_needed,
	output logic [5:0]  shift_amount,
	output logic        status
);

	udmg_state_t state_q, state_d;

	logic [4:0]  cnt_q;
	logic [31:0] d_q, nc_q;
	logic [31:0] q1_q, r1_q, q2_q, r2_q;
	logic [6:0]  p_q;
	logic        addf_q;

	// shared divider
	logic [31:0] dvd_q, dvs_q, rem_q;
	logic [32:0] div_shift;
	logic [32:0] div_diff;
	logic        div_ge;
	logic [31:0] div_rem_n, div_quo_n;
	logic        div_last;

	// doubling step
	logic [31:0] r1_dbl, q1_n, r1_n, q2_n, r2_n, delta;
	logic        ge1, ge2, ovf, more;
	logic [6:0]  p_n;
	logic        loop_finish;

	logic accept;
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		div_shift = {rem_q, dvd_q[WordBits-1]};
		div_diff  = div_shift - {1'b0, dvs_q};
		div_ge    = !div_diff[32];
		div_rem_n = div_ge ? div_diff[31:0] : div_shift[31:0];
		div_quo_n = {dvd_q[30:0], div_ge};
		div_last  = (cnt_q == 5'd31);
	end

	always_comb begin
		r1_dbl = {r1_q[30:0], 1'b0};
		ge1    = r1_q >= (nc_q - r1_q);
		q1_n   = {q1_q[30:0], ge1};
		r1_n   = ge1 ? (r1_dbl - nc_q) : r1_dbl;
		ge2    = (r2_q + 32'd1) >= (d_q - r2_q);
		ovf    = ge2 ? (q2_q >= LOW31) : (q2_q >= BIT31);
		q2_n   = {q2_q[30:0], ge2};
		r2_n   = {r2_q[30:0], 1'b1} - (ge2 ? d_q : 32'd0);
		delta  = d_q - 32'd1 - r2_n;
		more   = (q1_n < delta) || ((q1_n == delta) && (r1_n == 32'd0));
		p_n    = p_q + 7'd1;
		loop_finish = (p_n >= MAX_P) || !more;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (divisor == 32'd0) ? ST_DONE : ST_DIV_NC;
				end
			end
			ST_DIV_NC: begin
				if (div_last) state_d = ST_DIV_Q1;
			end
			ST_DIV_Q1: begin
				if (div_last) state_d = ST_DIV_Q2;
			end
			ST_DIV_Q2: begin
				if (div_last) state_d = ST_LOOP;
			end
			ST_LOOP: begin
				if (loop_finish) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 5'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV_NC || state_q == ST_DIV_Q1 || state_q == ST_DIV_Q2) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= 5'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					d_q    <= divisor;
					// first pass: (2^32 - d) mod d
					dvd_q  <= 32'd0 - divisor;
					dvs_q  <= divisor;
					rem_q  <= 32'd0;
					p_q    <= START_P;
					addf_q <= 1'b0;
					if (divisor == 32'd0) begin
						multiplier   <= 32'd0;
						add_needed   <= 1'b0;
						shift_amount <= 6'd0;
						status       <= 1'b1;
					end
				end
			end
			ST_DIV_NC: begin
				if (div_last) begin
					nc_q  <= ~div_rem_n;
					dvd_q <= BIT31;
					dvs_q <= ~div_rem_n;
					rem_q <= 32'd0;
				end else begin
					dvd_q <= div_quo_n;
					rem_q <= div_rem_n;
				end
			end
			ST_DIV_Q1: begin
				if (div_last) begin
					q1_q  <= div_quo_n;
					r1_q  <= div_rem_n;
					dvd_q <= LOW31;
					dvs_q <= d_q;
					rem_q <= 32'd0;
				end else begin
					dvd_q <= div_quo_n;
					rem_q <= div_rem_n;
				end
			end
			ST_DIV_Q2: begin
				dvd_q <= div_quo_n;
				rem_q <= div_rem_n;
				if (div_last) begin
					q2_q <= div_quo_n;
					r2_q <= div_rem_n;
				end
			end
			ST_LOOP: begin
				q1_q   <= q1_n;
				r1_q   <= r1_n;
				q2_q   <= q2_n;
				r2_q   <= r2_n;
				p_q    <= p_n;
				addf_q <= addf_q | ovf;
				if (loop_finish) begin
					multiplier   <= q2_n + 32'd1;
					add_needed   <= addf_q | ovf;
					shift_amount <= 6'(p_n - WORD_BITS);
					status       <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted word");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (multiplier == 32'd0 && !add_needed && shift_amount == 6'd0))
		else $error("zero divisor result not all zero");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !status) |-> (shift_amount <= 6'd32))
		else $error("post-shift out of range");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_LOOP || $past(state_q) == ST_IDLE))
		else $error("done reached from an unexpected state");

endmodule
